>>> src/tmps_pkg.sv
package tmps_pkg;

  localparam int VAL_W   = 32;
  localparam int REG_W   = 31;
  localparam int TIME_BITS = 16;
  localparam int TIME_W  = TIME_BITS + 1;
  localparam int MUL_W   = 35;
  localparam int PROD_W  = 2 * MUL_W;
  localparam int RAD_W   = 64;
  localparam int ROOT_W  = RAD_W / 2;
  localparam int DIV_W   = 64;

  localparam logic [REG_W-1:0]  REG_RESET = 31'd65536;
  localparam logic [TIME_W-1:0] TIME_CAP  = 17'h10000;

  typedef enum logic {
    REG_MAX_VELOCITY     = 1'b0,
    REG_MAX_ACCELERATION = 1'b1
  } reg_idx_t;

  typedef enum logic {
    CMD_ADVANCE = 1'b0,
    CMD_CLEAR   = 1'b1
  } cmd_t;

  typedef enum logic [4:0] {
    ST_IDLE,
    ST_SQ_V0,
    ST_SQ_VG,
    ST_MUL_AD,
    ST_SUM_S,
    ST_ROOT1_GO,
    ST_ROOT1_WAIT,
    ST_ROOT2_GO,
    ST_ROOT2_WAIT,
    ST_VV,
    ST_PQ,
    ST_CT_GO,
    ST_CT_WAIT,
    ST_ST_GO,
    ST_ST_WAIT,
    ST_ET_GO,
    ST_ET_WAIT,
    ST_KSEL,
    ST_K1,
    ST_K2,
    ST_K3,
    ST_DONE
  } state_t;

  // Clamp a widened sum back into the signed 32-bit range.
  function automatic logic signed [VAL_W-1:0] sat35(input logic signed [34:0] x);
    logic signed [34:0] hi;
    logic signed [34:0] lo;
    hi = $signed({3'b000, 32'h7FFF_FFFF});
    lo = $signed({3'b111, 32'h8000_0000});
    if (x > hi) begin
      return 32'sh7FFF_FFFF;
    end else if (x < lo) begin
      return 32'sh8000_0000;
    end else begin
      return x[VAL_W-1:0];
    end
  endfunction

endpackage

>>> src/tmps_if.sv
interface tmps_req_if import tmps_pkg::*; ();
  logic              valid;
  logic              ready;
  logic              cmd;
  logic signed [31:0] distance_left;
  logic signed [31:0] measured_velocity;
  logic signed [31:0] goal_velocity;
  logic [15:0]       step_time;

  modport source (output valid, cmd, distance_left, measured_velocity, goal_velocity,
                  step_time, input ready);
  modport sink (input valid, cmd, distance_left, measured_velocity, goal_velocity,
                step_time, output ready);
endinterface

interface tmps_rsp_if import tmps_pkg::*; ();
  logic              valid;
  logic              ready;
  logic signed [31:0] position;
  logic signed [31:0] velocity;
  logic signed [31:0] acceleration;

  modport source (output valid, position, velocity, acceleration, input ready);
  modport sink (input valid, position, velocity, acceleration, output ready);
endinterface

interface tmps_cfg_if import tmps_pkg::*; ();
  logic             valid;
  logic             ready;
  reg_idx_t         index;
  logic [REG_W-1:0] data;

  modport source (output valid, index, data, input ready);
  modport sink (input valid, index, data, output ready);
endinterface

>>> src/tmps_mul.sv
module tmps_mul import tmps_pkg::*; (
  input  logic                     clk,
  input  logic signed [MUL_W-1:0]  a,
  input  logic signed [MUL_W-1:0]  b,
  output logic signed [PROD_W-1:0] p
);

  // Product is registered; the sequencer uses it in the cycle after issuing.
  always_ff @(posedge clk) begin
    p <= a * b;
  end

endmodule

>>> src/tmps_sqrt.sv
module tmps_sqrt import tmps_pkg::*; (
  input  logic              clk,
  input  logic              rst,
  input  logic              start,
  input  logic [RAD_W-1:0]  x,
  output logic              done,
  output logic [ROOT_W-1:0] root
);

  // One result bit per cycle, two radicand bits consumed per step.
  logic [RAD_W-1:0]  xr;
  logic [33:0]       remr;
  logic [4:0]        cnt;
  logic              busy;
  logic [35:0]       rem_sh;
  logic [35:0]       trial;
  logic              fits;

  assign rem_sh = {remr, xr[RAD_W-1 -: 2]};
  assign trial  = {2'b00, root, 2'b01};
  assign fits   = rem_sh >= trial;

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        cnt  <= '0;
      end else if (busy) begin
        cnt <= cnt + 5'd1;
        if (cnt == 5'd31) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      xr   <= x;
      remr <= '0;
      root <= '0;
    end else if (busy) begin
      xr <= {xr[RAD_W-3:0], 2'b00};
      if (fits) begin
        remr <= 34'(rem_sh - trial);
        root <= {root[ROOT_W-2:0], 1'b1};
      end else begin
        remr <= rem_sh[33:0];
        root <= {root[ROOT_W-2:0], 1'b0};
      end
    end
  end

endmodule

>>> src/tmps_div.sv
module tmps_div import tmps_pkg::*; (
  input  logic              clk,
  input  logic              rst,
  input  logic              start,
  input  logic [DIV_W-1:0]  num,
  input  logic [DIV_W-1:0]  den,
  output logic              done,
  output logic [TIME_W-1:0] quo
);

  // Restoring fraction divider: one quotient bit per cycle.
  logic [DIV_W-1:0]     r;
  logic [DIV_W-1:0]     d;
  logic [TIME_BITS-1:0] q;
  logic [3:0]           cnt;
  logic                 busy;
  logic [DIV_W:0]       rs;
  logic                 ge;

  assign rs = {r, 1'b0};
  assign ge = rs >= {1'b0, d};

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        cnt <= '0;
        if (den == '0 || num >= den) begin
          done <= 1'b1;
        end else begin
          busy <= 1'b1;
        end
      end else if (busy) begin
        cnt <= cnt + 4'd1;
        if (cnt == 4'd15) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      r   <= num;
      d   <= den;
      q   <= '0;
      quo <= TIME_CAP;
    end else if (busy) begin
      if (ge) begin
        r <= DIV_W'(rs - {1'b0, d});
      end else begin
        r <= rs[DIV_W-1:0];
      end
      q <= {q[TIME_BITS-2:0], ge};
      if (cnt == 4'd15) begin
        quo <= {1'b0, q[TIME_BITS-2:0], ge};
      end
    end
  end

endmodule

>>> src/trapezoidal_motion_profile_step.sv
// Sequence: a clear request goes from acceptance straight to the done state, where its
// result register loads; an advance request runs at most two square roots, three
// divisions and four integration phases, or only the four phases when the distance is zero.
// Throughput: one request at a time; the next is taken in the cycle after the result
// register loads, and a result left waiting there stalls the sequencer and the input.
// Reset (synchronous, active high) zeroes the setpoint and loads both limits with 1.0.
module trapezoidal_motion_profile_step import tmps_pkg::*; (
  input  logic         clk,
  input  logic         rst,
  tmps_cfg_if.sink     cfg,
  tmps_req_if.sink     req,
  tmps_rsp_if.source   rsp
);

  // Limit registers, written over the configuration channel.
  logic [REG_W-1:0] max_vel;
  logic [REG_W-1:0] max_acc;
  logic [REG_W-1:0] a_lim;
  logic [REG_W-1:0] v_lim;

  // Setpoint state.
  logic signed [VAL_W-1:0] pos;
  logic signed [VAL_W-1:0] vel;
  logic signed [VAL_W-1:0] acc;

  // Result register that decouples the sequencer from the consumer.
  logic                    out_valid;
  logic signed [VAL_W-1:0] out_pos;
  logic signed [VAL_W-1:0] out_vel;
  logic signed [VAL_W-1:0] out_acc;

  state_t state;
  state_t state_next;

  // Planning registers. Velocities are held mirrored when the distance is negative.
  logic                  neg;
  logic signed [32:0]    dist_abs;
  logic signed [32:0]    v0;
  logic signed [32:0]    vg;
  logic [TIME_BITS-1:0]  rem;
  logic [63:0]           v0s;
  logic [63:0]           vgs;
  logic [63:0]           s;
  logic                  fin_neg;
  logic [ROOT_W-1:0]     top;
  logic                  pq_gt;
  logic [63:0]           pq_diff;
  logic [TIME_W-1:0]     st;
  logic [TIME_W-1:0]     ct;
  logic [TIME_W-1:0]     et;
  logic signed [VAL_W-1:0] sa;
  logic signed [VAL_W-1:0] ea;

  // Integration registers.
  logic [1:0]              ph;
  logic                    klast;
  logic [TIME_BITS-1:0]    kt;
  logic signed [VAL_W-1:0] ka;
  logic signed [VAL_W-1:0] dv;

  // Shared units.
  logic signed [MUL_W-1:0]  mul_a;
  logic signed [MUL_W-1:0]  mul_b;
  logic signed [PROD_W-1:0] mul_p;
  logic                     sqrt_start;
  logic [RAD_W-1:0]         sqrt_x;
  logic                     sqrt_done;
  logic [ROOT_W-1:0]        sqrt_root;
  logic                     div_start;
  logic [DIV_W-1:0]         div_num;
  logic [DIV_W-1:0]         div_den;
  logic                     div_done;
  logic [TIME_W-1:0]        div_quo;

  // Derived values.
  logic                    req_fire;
  logic                    out_load;
  logic                    req_neg;
  logic signed [32:0]      req_d;
  logic signed [32:0]      req_v0;
  logic signed [32:0]      req_vg;
  logic [63:0]           p_full;
  logic [63:0]           pq_p;
  logic [63:0]           pq_q;
  logic                    root_ge_vg;
  logic                    top_gt_v;
  logic signed [33:0]      top_ext;
  logic signed [33:0]      top_m_v0;
  logic signed [33:0]      endnum;
  logic [TIME_W-1:0]       tp;
  logic                    sel_last;
  logic signed [VAL_W-1:0] dv_now;
  logic signed [33:0]      vel2;
  logic signed [33:0]      dp;
  logic signed [34:0]      pos_sum;
  logic signed [34:0]      vel_sum;

  // A limit of zero behaves as the smallest nonzero limit.
  assign a_lim = (max_acc == '0) ? REG_W'(1) : max_acc;
  assign v_lim = (max_vel == '0) ? REG_W'(1) : max_vel;

  assign req_fire = req.valid && req.ready;
  assign out_load = (state == ST_DONE) && (!out_valid || rsp.ready);

  // A negative distance is planned as the mirrored positive problem.
  assign req_neg = req.distance_left[VAL_W-1];
  assign req_d   = req_neg ? -{req.distance_left[31], req.distance_left}
                           : {req.distance_left[31], req.distance_left};
  assign req_v0  = req_neg ? -{req.measured_velocity[31], req.measured_velocity}
                           : {req.measured_velocity[31], req.measured_velocity};
  assign req_vg  = req_neg ? -{req.goal_velocity[31], req.goal_velocity}
                           : {req.goal_velocity[31], req.goal_velocity};

  assign p_full     = s + vgs;
  assign pq_p       = fin_neg ? p_full : s;
  assign pq_q       = fin_neg ? {mul_p[62:0], 1'b0} : vgs;
  assign root_ge_vg = $signed({2'b00, sqrt_root}) >= $signed({vg[32], vg});
  assign top_gt_v   = top > {1'b0, v_lim};
  assign top_ext    = $signed({2'b00, top});
  assign top_m_v0   = top_ext - {v0[32], v0};
  assign endnum     = fin_neg ? (top_ext - {vg[32], vg}) : ({vg[32], vg} - top_ext);

  // Phase times in order: accelerate, cruise, final ramp; the fourth is coasting.
  always_comb begin
    case (ph)
      2'd0:    tp = st;
      2'd1:    tp = ct;
      2'd2:    tp = et;
      default: tp = '0;
    endcase
  end
  assign sel_last = (ph == 2'd3) || (tp > {1'b0, rem});

  // Kinematics: dv = floor(a*t / 2^16), dp = floor((2v + dv)*t / 2^17).
  assign dv_now  = mul_p[47:16];
  assign vel2    = {vel[31], vel, 1'b0} + {{2{dv_now[31]}}, dv_now};
  assign dp      = mul_p[50:17];
  assign pos_sum = {{3{pos[31]}}, pos} + {dp[33], dp};
  assign vel_sum = {{3{vel[31]}}, vel} + {{3{dv[31]}}, dv};

  tmps_mul u_mul (
    .clk (clk),
    .a   (mul_a),
    .b   (mul_b),
    .p   (mul_p)
  );

  tmps_sqrt u_sqrt (
    .clk   (clk),
    .rst   (rst),
    .start (sqrt_start),
    .x     (sqrt_x),
    .done  (sqrt_done),
    .root  (sqrt_root)
  );

  tmps_div u_div (
    .clk   (clk),
    .rst   (rst),
    .start (div_start),
    .num   (div_num),
    .den   (div_den),
    .done  (div_done),
    .quo   (div_quo)
  );

  // Next-state logic of the sequencer.
  always_comb begin
    state_next = state;
    case (state)
      ST_IDLE: begin
        if (req_fire) begin
          if (req.cmd == CMD_CLEAR) begin
            state_next = ST_DONE;
          end else if (req.distance_left == '0) begin
            state_next = ST_KSEL;
          end else begin
            state_next = ST_SQ_V0;
          end
        end
      end
      ST_SQ_V0:    state_next = ST_SQ_VG;
      ST_SQ_VG:    state_next = ST_MUL_AD;
      ST_MUL_AD:   state_next = ST_SUM_S;
      ST_SUM_S:    state_next = ST_ROOT1_GO;
      ST_ROOT1_GO: state_next = ST_ROOT1_WAIT;
      ST_ROOT1_WAIT: begin
        if (sqrt_done) begin
          state_next = root_ge_vg ? ST_ROOT2_GO : ST_VV;
        end
      end
      ST_ROOT2_GO: state_next = ST_ROOT2_WAIT;
      ST_ROOT2_WAIT: begin
        if (sqrt_done) begin
          state_next = ST_VV;
        end
      end
      ST_VV:       state_next = top_gt_v ? ST_PQ : ST_ST_GO;
      ST_PQ:       state_next = ST_CT_GO;
      ST_CT_GO:    state_next = pq_gt ? ST_CT_WAIT : ST_ST_GO;
      ST_CT_WAIT: begin
        if (div_done) begin
          state_next = ST_ST_GO;
        end
      end
      ST_ST_GO:    state_next = (top_m_v0 > 0) ? ST_ST_WAIT : ST_ET_GO;
      ST_ST_WAIT: begin
        if (div_done) begin
          state_next = ST_ET_GO;
        end
      end
      ST_ET_GO:    state_next = (endnum > 0) ? ST_ET_WAIT : ST_KSEL;
      ST_ET_WAIT: begin
        if (div_done) begin
          state_next = ST_KSEL;
        end
      end
      ST_KSEL:     state_next = ST_K1;
      ST_K1:       state_next = ST_K2;
      ST_K2:       state_next = ST_K3;
      ST_K3:       state_next = klast ? ST_DONE : ST_KSEL;
      ST_DONE: begin
        if (out_load) begin
          state_next = ST_IDLE;
        end
      end
      default:     state_next = ST_IDLE;
    endcase
  end

  // Sequencer outputs: operand selection and unit starts.
  always_comb begin
    mul_a      = '0;
    mul_b      = '0;
    sqrt_start = 1'b0;
    sqrt_x     = s;
    div_start  = 1'b0;
    div_num    = pq_diff;
    div_den    = {mul_p[62:0], 1'b0};
    req.ready  = (state == ST_IDLE);
    case (state)
      ST_SQ_V0: begin
        mul_a = {{2{v0[32]}}, v0};
        mul_b = {{2{v0[32]}}, v0};
      end
      ST_SQ_VG: begin
        mul_a = {{2{vg[32]}}, vg};
        mul_b = {{2{vg[32]}}, vg};
      end
      ST_MUL_AD: begin
        mul_a = {4'b0000, a_lim};
        mul_b = {{2{dist_abs[32]}}, dist_abs};
      end
      ST_ROOT1_GO: begin
        sqrt_start = 1'b1;
      end
      ST_ROOT2_GO: begin
        sqrt_start = 1'b1;
        sqrt_x     = {1'b0, p_full[63:1]};
      end
      ST_VV: begin
        mul_a = {4'b0000, v_lim};
        mul_b = {4'b0000, v_lim};
      end
      ST_PQ: begin
        mul_a = {4'b0000, a_lim};
        mul_b = {4'b0000, v_lim};
      end
      ST_CT_GO: begin
        div_start = pq_gt;
      end
      ST_ST_GO: begin
        div_start = top_m_v0 > 0;
        div_num   = 64'(top_m_v0[32:0]);
        div_den   = 64'(a_lim);
      end
      ST_ET_GO: begin
        div_start = endnum > 0;
        div_num   = 64'(endnum[32:0]);
        div_den   = 64'(a_lim);
      end
      ST_K1: begin
        mul_a = {{3{ka[31]}}, ka};
        mul_b = MUL_W'(kt);
      end
      ST_K2: begin
        mul_a = {vel2[33], vel2};
        mul_b = MUL_W'(kt);
      end
      default: begin
      end
    endcase
  end

  assign cfg.ready = 1'b1;

  // Control state, limits and setpoint.
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_IDLE;
      max_vel   <= REG_RESET;
      max_acc   <= REG_RESET;
      pos       <= '0;
      vel       <= '0;
      acc       <= '0;
      out_valid <= 1'b0;
    end else begin
      state <= state_next;
      if (cfg.valid && cfg.ready) begin
        case (cfg.index)
          REG_MAX_VELOCITY:     max_vel <= cfg.data;
          REG_MAX_ACCELERATION: max_acc <= cfg.data;
          default: begin
          end
        endcase
      end
      if (req_fire && req.cmd == CMD_CLEAR) begin
        pos <= '0;
        vel <= '0;
        acc <= '0;
      end
      if (state == ST_K3) begin
        acc <= ka;
        pos <= sat35(pos_sum);
        vel <= sat35(vel_sum);
      end
      if (out_load) begin
        out_valid <= 1'b1;
      end else if (rsp.ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  // Datapath registers of the planner and integrator.
  always_ff @(posedge clk) begin
    case (state)
      ST_IDLE: begin
        if (req_fire) begin
          neg      <= req_neg;
          dist_abs <= req_d;
          v0       <= req_v0;
          vg       <= req_vg;
          rem      <= req.step_time;
          ph       <= '0;
          // Zero distance: every phase is empty and coasting takes the whole step.
          st   <= '0;
          ct   <= '0;
          et   <= '0;
          sa   <= '0;
          ea   <= '0;
        end
      end
      ST_SQ_VG:  v0s <= mul_p[63:0];
      ST_MUL_AD: vgs <= mul_p[63:0];
      ST_SUM_S:  s   <= {mul_p[62:0], 1'b0} + v0s;
      ST_ROOT1_WAIT: begin
        if (sqrt_done) begin
          fin_neg <= root_ge_vg;
          top     <= sqrt_root;
        end
      end
      ST_ROOT2_WAIT: begin
        if (sqrt_done) begin
          top <= sqrt_root;
        end
      end
      ST_PQ: begin
        pq_gt   <= pq_p > pq_q;
        pq_diff <= pq_p - pq_q;
      end
      ST_CT_GO: begin
        top <= ROOT_W'(v_lim);
      end
      ST_CT_WAIT: begin
        if (div_done) begin
          ct <= div_quo;
        end
      end
      ST_ST_WAIT: begin
        if (div_done) begin
          st <= div_quo;
        end
      end
      ST_ET_GO: begin
        sa <= neg ? -$signed({1'b0, a_lim}) : $signed({1'b0, a_lim});
        ea <= (neg ^ fin_neg) ? -$signed({1'b0, a_lim}) : $signed({1'b0, a_lim});
      end
      ST_ET_WAIT: begin
        if (div_done) begin
          et <= div_quo;
        end
      end
      ST_KSEL: begin
        klast <= sel_last;
        kt    <= sel_last ? rem : tp[TIME_BITS-1:0];
        if (!sel_last) begin
          rem <= rem - tp[TIME_BITS-1:0];
        end
        case (ph)
          2'd0:    ka <= sa;
          2'd2:    ka <= ea;
          default: ka <= '0;
        endcase
      end
      ST_K2: begin
        dv <= dv_now;
      end
      ST_K3: begin
        ph <= ph + 2'd1;
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      if (state_next == ST_IDLE && pos == '0 && vel == '0 && acc == '0) begin
        out_pos <= '0;
      end else begin
        out_pos <= pos;
      end
      out_vel <= vel;
      out_acc <= acc;
    end
  end

  assign rsp.valid        = out_valid;
  assign rsp.position     = out_pos;
  assign rsp.velocity     = out_vel;
  assign rsp.acceleration = out_acc;

endmodule

>>> dv/testbench.sv
module testbench;
  import tmps_pkg::*;
  timeunit 1ns;
  timeprecision 1ps;

  // One request, as the driver presents it on the request channel.
  typedef struct {
    cmd_t               cmd;
    logic signed [31:0] span;
    logic signed [31:0] vel_now;
    logic signed [31:0] vel_goal;
    logic [15:0]        dt;
  } step_req_t;

  // The setpoint that the block reports after each request.
  typedef struct {
    logic signed [31:0] pos;
    logic signed [31:0] vel;
    logic signed [31:0] acc;
  } setpoint_t;

  // The watchdog limit covers the slowest request, the random driver and receiver gaps,
  // and the one long receiver hold-off, with a wide margin.
  localparam int WATCHDOG_LIMIT = 5000;
  localparam int SETTLE_CYCLES  = 200;
  localparam int HOLD_CYCLES    = 600;

  logic clk;
  logic rst;

  tmps_cfg_if cfg_bus();
  tmps_req_if req_bus();
  tmps_rsp_if rsp_bus();

  trapezoidal_motion_profile_step uut (
    .clk (clk),
    .rst (rst),
    .cfg (cfg_bus),
    .req (req_bus),
    .rsp (rsp_bus)
  );

  // Requests waiting for the driver, and setpoints the block still owes us.
  step_req_t pending_steps[$];
  setpoint_t owed_setpoints[$];

  // Shadow copy of the block's limits and its setpoint state.
  logic [REG_W-1:0] lim_vel;
  logic [REG_W-1:0] lim_acc;
  longint           pos_s;
  longint           vel_s;
  longint           acc_s;

  int  errors;
  int  results_seen;
  int  quiet_cycles;
  bit  req_fired;
  bit  rsp_fired;
  bit  drv_busy;
  int  drv_gap;
  int  rx_gap;
  int  rx_hold;
  bit  hold_done;

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // Clamp a wide signed value into the 32-bit range, as the block saturates.
  function automatic longint clamp32(input longint x);
    if (x > 64'sd2147483647) begin
      return 64'sd2147483647;
    end
    if (x < -64'sd2147483648) begin
      return -64'sd2147483648;
    end
    return x;
  endfunction

  // Floor integer square root of a 64-bit radicand.
  function automatic longint unsigned int_root(input longint unsigned x);
    longint unsigned res;
    longint unsigned bitv;
    res = 0;
    bitv = 64'd1 << 62;
    while (bitv > x) begin
      bitv = bitv >> 2;
    end
    while (bitv != 0) begin
      if (x >= res + bitv) begin
        x = x - (res + bitv);
        res = (res >> 1) + bitv;
      end else begin
        res = res >> 1;
      end
      bitv = bitv >> 2;
    end
    return res;
  endfunction

  // Ratio num/den as a Q0.16 time; one second or more reads as the time cap.
  function automatic longint unsigned phase_time(input longint unsigned num,
                                                 input longint unsigned den);
    longint unsigned q;
    longint unsigned r;
    if (den == 0 || num >= den) begin
      return 64'h10000;
    end
    q = 0;
    r = num;
    for (int i = 0; i < TIME_BITS; i++) begin
      r = r << 1;
      q = q << 1;
      if (r >= den) begin
        r = r - den;
        q = q | 64'd1;
      end
    end
    return q;
  endfunction

  // Integrate the setpoint through one phase of constant acceleration.
  function automatic void integrate(input longint a, input longint unsigned t);
    longint ti;
    longint dv;
    longint dp;
    ti = longint'(t);
    dv = (a * ti) >>> 16;
    dp = ((2 * vel_s + dv) * ti) >>> 17;
    acc_s = a;
    pos_s = clamp32(pos_s + dp);
    vel_s = clamp32(vel_s + dv);
  endfunction

  // Plan the profile for one request, advance the shadow state through it, and
  // return the setpoint the block should report.
  function automatic setpoint_t plan_and_advance(input step_req_t r);
    setpoint_t       sp;
    longint          d, v0, vg, amax, vmax, sa, ea, fin, top, endnum;
    longint unsigned rem, st, ct, et, v0s, vgs, s, vach, p, q;
    bit              neg;
    if (r.cmd == CMD_CLEAR) begin
      pos_s = 0;
      vel_s = 0;
      acc_s = 0;
    end else begin
      d = longint'(r.span);
      v0 = longint'(r.vel_now);
      vg = longint'(r.vel_goal);
      rem = longint'(r.dt);
      amax = (lim_acc == 0) ? 64'sd1 : longint'({33'd0, lim_acc});
      vmax = (lim_vel == 0) ? 64'sd1 : longint'({33'd0, lim_vel});
      sa = 0;
      ea = 0;
      st = 0;
      ct = 0;
      et = 0;
      if (d != 0) begin
        // A move in the negative direction is planned as its mirror image.
        neg = (d < 0);
        if (neg) begin
          d = -d;
          v0 = -v0;
          vg = -vg;
        end
        v0s = v0 * v0;
        vgs = vg * vg;
        s = 64'd2 * amax * d + v0s;
        vach = int_root(s);
        if (longint'(vach) >= vg) begin
          fin = -amax;
          top = longint'(int_root((s + vgs) >> 1));
        end else begin
          fin = amax;
          top = longint'(vach);
        end
        if (top > vmax) begin
          if (fin < 0) begin
            p = s + vgs;
            q = 64'd2 * vmax * vmax;
          end else begin
            p = s;
            q = vgs;
          end
          ct = (p > q) ? phase_time(p - q, 64'd2 * amax * vmax) : 64'd0;
          top = vmax;
        end
        st = (top > v0) ? phase_time(top - v0, amax) : 64'd0;
        endnum = (fin < 0) ? top - vg : vg - top;
        et = (endnum > 0) ? phase_time(endnum, amax) : 64'd0;
        sa = neg ? -amax : amax;
        ea = neg ? -fin : fin;
      end
      // Each phase is cut short by whatever is left of the step.
      if (st > rem) begin
        integrate(sa, rem);
      end else begin
        integrate(sa, st);
        rem = rem - st;
        if (ct > rem) begin
          integrate(0, rem);
        end else begin
          integrate(0, ct);
          rem = rem - ct;
          if (et > rem) begin
            integrate(ea, rem);
          end else begin
            integrate(ea, et);
            rem = rem - et;
            integrate(0, rem);
          end
        end
      end
    end
    sp.pos = pos_s[31:0];
    sp.vel = vel_s[31:0];
    sp.acc = acc_s[31:0];
    return sp;
  endfunction

  function automatic step_req_t make_step(input cmd_t c, input int d, input int v0,
                                          input int vg, input int dt);
    step_req_t r;
    r.cmd = c;
    r.span = d;
    r.vel_now = v0;
    r.vel_goal = vg;
    r.dt = dt[15:0];
    return r;
  endfunction

  // Random request: mostly plausible moves with small steps, some raw noise on
  // every bit, and an occasional clear.
  function automatic step_req_t random_step();
    step_req_t r;
    int        mode;
    int        mag;
    mode = $urandom_range(0, 19);
    if (mode == 0) begin
      r = make_step(CMD_CLEAR, $urandom, $urandom, $urandom, $urandom);
    end else if (mode < 5) begin
      r = make_step(CMD_ADVANCE, $urandom, $urandom, $urandom, $urandom);
    end else begin
      mag = $urandom_range(0, 1 << ($urandom_range(4, 26)));
      r.cmd = CMD_ADVANCE;
      r.span = $urandom_range(0, 1) ? mag : -mag;
      r.vel_now = $signed($urandom_range(0, 1 << 18)) - (1 << 17) + vel_s[31:0];
      r.vel_goal = ($urandom_range(0, 3) == 0) ? 0 :
                   $signed($urandom_range(0, 1 << 19)) - (1 << 18);
      r.dt = ($urandom_range(0, 7) == 0) ? 16'($urandom_range(0, 65535)) :
             16'($urandom_range(0, 6554));
    end
    return r;
  endfunction

  // Drive the request channel from the pending queue, with a random gap before
  // each request and calm stretches where the gap is always zero.
  always @(negedge clk) begin
    step_req_t nxt;
    if (rst) begin
      drv_busy = 1'b0;
      drv_gap = 0;
      req_bus.valid <= 1'b0;
    end else begin
      if (drv_busy && req_fired) begin
        drv_busy = 1'b0;
        drv_gap = ((results_seen / 50) % 3 == 0) ? 0 : $urandom_range(0, 14);
      end
      if (!drv_busy) begin
        if (drv_gap > 0) begin
          drv_gap--;
        end else if (pending_steps.size() > 0) begin
          nxt = pending_steps.pop_front();
          drv_busy = 1'b1;
          req_bus.cmd <= nxt.cmd;
          req_bus.distance_left <= nxt.span;
          req_bus.measured_velocity <= nxt.vel_now;
          req_bus.goal_velocity <= nxt.vel_goal;
          req_bus.step_time <= nxt.dt;
        end
      end
      req_bus.valid <= drv_busy;
    end
  end

  // The receiver stalls a random number of cycles per result. Once, after a
  // hundred results, it holds off for a long stretch so the block backs up.
  always @(negedge clk) begin
    if (rst) begin
      rx_gap = 0;
      rx_hold = 0;
      hold_done = 1'b0;
      rsp_bus.ready <= 1'b0;
    end else begin
      if (rsp_fired) begin
        rx_gap = ((results_seen / 40) % 4 == 1) ? 0 : $urandom_range(0, 14);
        if (!hold_done && results_seen >= 100) begin
          hold_done = 1'b1;
          rx_hold = HOLD_CYCLES;
        end
      end else if (rx_hold > 0) begin
        rx_hold--;
      end else if (rx_gap > 0) begin
        rx_gap--;
      end
      rsp_bus.ready <= (rx_gap == 0 && rx_hold == 0);
    end
  end

  // Monitor: predict on each accepted request, check each accepted result, keep
  // the shadow limits in step with register writes, and run the watchdog.
  always @(posedge clk) begin
    step_req_t r;
    setpoint_t want;
    bit        moved;
    req_fired <= !rst && req_bus.valid && req_bus.ready;
    rsp_fired <= !rst && rsp_bus.valid && rsp_bus.ready;
    if (!rst) begin
      moved = 1'b0;
      if (cfg_bus.valid && cfg_bus.ready) begin
        moved = 1'b1;
        if (cfg_bus.index == REG_MAX_VELOCITY) begin
          lim_vel = cfg_bus.data;
        end else begin
          lim_acc = cfg_bus.data;
        end
      end
      if (req_bus.valid && req_bus.ready) begin
        moved = 1'b1;
        r.cmd = cmd_t'(req_bus.cmd);
        r.span = req_bus.distance_left;
        r.vel_now = req_bus.measured_velocity;
        r.vel_goal = req_bus.goal_velocity;
        r.dt = req_bus.step_time;
        owed_setpoints.push_back(plan_and_advance(r));
      end
      if (rsp_bus.valid && rsp_bus.ready) begin
        moved = 1'b1;
        results_seen++;
        if (owed_setpoints.size() == 0) begin
          errors++;
          $display("%0t: unexpected result pos=%h vel=%h acc=%h", $time,
                   rsp_bus.position, rsp_bus.velocity, rsp_bus.acceleration);
        end else begin
          want = owed_setpoints.pop_front();
          if (rsp_bus.position !== want.pos) begin
            errors++;
            $display("%0t: position expected %h actual %h", $time, want.pos,
                     rsp_bus.position);
          end
          if (rsp_bus.velocity !== want.vel) begin
            errors++;
            $display("%0t: velocity expected %h actual %h", $time, want.vel,
                     rsp_bus.velocity);
          end
          if (rsp_bus.acceleration !== want.acc) begin
            errors++;
            $display("%0t: acceleration expected %h actual %h", $time, want.acc,
                     rsp_bus.acceleration);
          end
        end
      end
      quiet_cycles = moved ? 0 : quiet_cycles + 1;
      if (quiet_cycles >= WATCHDOG_LIMIT) begin
        $display("testbench: errors");
        $finish;
      end
    end
  end

  // Register write, presented at the falling edge and held until accepted.
  task automatic write_limit(input reg_idx_t idx, input logic [REG_W-1:0] value);
    @(negedge clk);
    cfg_bus.valid <= 1'b1;
    cfg_bus.index <= idx;
    cfg_bus.data <= value;
    @(posedge clk);
    while (!cfg_bus.ready) begin
      @(posedge clk);
    end
    @(negedge clk);
    cfg_bus.valid <= 1'b0;
  endtask

  // Block until every queued request has gone in and every result has come back,
  // then give the block its full latency before touching the registers.
  task automatic wait_drained();
    while (pending_steps.size() > 0 || drv_busy || owed_setpoints.size() > 0) begin
      @(posedge clk);
    end
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  initial begin
    logic [REG_W-1:0] vel_set[6];
    logic [REG_W-1:0] acc_set[6];
    errors = 0;
    results_seen = 0;
    quiet_cycles = 0;
    lim_vel = REG_RESET;
    lim_acc = REG_RESET;
    pos_s = 0;
    vel_s = 0;
    acc_s = 0;
    rst = 1'b1;
    cfg_bus.valid = 1'b0;
    cfg_bus.index = REG_MAX_VELOCITY;
    cfg_bus.data = '0;
    req_bus.valid = 1'b0;
    req_bus.cmd = CMD_ADVANCE;
    req_bus.distance_left = '0;
    req_bus.measured_velocity = '0;
    req_bus.goal_velocity = '0;
    req_bus.step_time = '0;
    rsp_bus.ready = 1'b0;
    repeat (2) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    // Directed requests under the reset limits of 1.0: zero distance, both
    // signs, field extremes, an unreachable goal velocity, a cruise plateau,
    // zero and full step lengths, and a clear in the middle.
    pending_steps.push_back(make_step(CMD_ADVANCE, 0, 0, 0, 65535));
    pending_steps.push_back(make_step(CMD_ADVANCE, 0, 32'h4000_0000, -5, 6554));
    pending_steps.push_back(make_step(CMD_ADVANCE, 65536, 0, 0, 6554));
    pending_steps.push_back(make_step(CMD_ADVANCE, -65536, 0, 0, 6554));
    pending_steps.push_back(make_step(CMD_ADVANCE, 32'h7FFF_FFFF, 0, 0, 65535));
    pending_steps.push_back(make_step(CMD_ADVANCE, 32'h8000_0000, 0, 0, 65535));
    pending_steps.push_back(make_step(CMD_ADVANCE, 1 << 20, 32'h7FFF_FFFF, 0, 65535));
    pending_steps.push_back(make_step(CMD_ADVANCE, 1 << 20, 32'h8000_0000, 0, 65535));
    pending_steps.push_back(make_step(CMD_ADVANCE, 100, 0, 32'h7FFF_FFFF, 65535));
    pending_steps.push_back(make_step(CMD_ADVANCE, -100, 0, 32'h8000_0000, 65535));
    pending_steps.push_back(make_step(CMD_ADVANCE, 1 << 24, 65536, 0, 65535));
    pending_steps.push_back(make_step(CMD_ADVANCE, 1 << 24, 0, 0, 0));
    pending_steps.push_back(make_step(CMD_ADVANCE, 1 << 16, 1 << 15, 1 << 15, 30000));
    pending_steps.push_back(make_step(CMD_CLEAR, 32'h7FFF_FFFF, -1, -1, 65535));
    pending_steps.push_back(make_step(CMD_ADVANCE, 1, 0, 0, 1));
    pending_steps.push_back(make_step(CMD_ADVANCE, -1, -1, 1, 65535));
    pending_steps.push_back(make_step(CMD_ADVANCE, 1 << 18, -(1 << 17), 1 << 16, 40000));
    pending_steps.push_back(make_step(CMD_ADVANCE, -(1 << 18), 1 << 17, -(1 << 16), 40000));

    // Limit settings: reset values, both maxima, both minima, zero (acts as one),
    // a typical servo setting and a random one.
    vel_set = '{REG_RESET, 31'h7FFF_FFFF, 31'd1, 31'd0, 31'd655360, 31'd0};
    acc_set = '{REG_RESET, 31'h7FFF_FFFF, 31'd1, 31'd0, 31'd262144, 31'd0};
    vel_set[5] = REG_W'($urandom);
    acc_set[5] = REG_W'($urandom);
    for (int ph = 0; ph < 6; ph++) begin
      if (ph > 0) begin
        wait_drained();
        write_limit(REG_MAX_VELOCITY, vel_set[ph]);
        write_limit(REG_MAX_ACCELERATION, acc_set[ph]);
      end
      for (int i = 0; i < 155; i++) begin
        pending_steps.push_back(random_step());
      end
    end
    wait_drained();

    if (errors == 0) begin
      $display("testbench: clean");
    end else begin
      $display("testbench: errors");
    end
    $finish;
  end

endmodule
